@@ design/scm_pkg.sv @@
// Shared types and constants for the stack calculator machine.
// Used by scm_front, scm_back and stack_calculator_machine; no dependencies.
package scm_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [3:0] CMD_IN   = 4'd0;
  localparam logic [3:0] CMD_PUSH = 4'd1;
  localparam logic [3:0] CMD_DIV  = 4'd2;
  localparam logic [3:0] CMD_SUB  = 4'd3;
  localparam logic [3:0] CMD_OUT  = 4'd4;
  localparam logic [3:0] CMD_ADD  = 4'd5;
  localparam logic [3:0] CMD_MUL  = 4'd6;
  localparam logic [3:0] CMD_HALT = 4'd7;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_ARITH,
    K_HALT,
    K_BAD
  } kind_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_t;

  typedef struct packed {
    kind_t kind;
    alu_t  alu;
  } cmd_class_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPW,
    S_RD_T,
    S_RD_S,
    S_MUL,
    S_DIV,
    S_SAT,
    S_WR,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand;
  } calc_in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_present;
    status_t            status;
  } calc_out_t;

endpackage

@@ design/scm_front.sv @@
// Front end: accepts instructions, decodes them and converts the operand.
// Holds a two-entry queue toward scm_back. Depends on scm_pkg.
module scm_front import scm_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  calc_in_t               in_data,
  output logic                   q_valid,
  input  logic                   q_ready,
  output cmd_class_t             q_class,
  output logic [VALUE_WIDTH-1:0] q_value
);

  localparam logic signed [64:0] VMAX65 = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] VMIN65 = -VMAX65 - 65'sd1;

  cmd_class_t             cls_c;
  logic signed [64:0]     op65;
  logic signed [64:0]     sat65;
  cmd_class_t             cls_r [2];
  logic [VALUE_WIDTH-1:0] val_r [2];
  logic                   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   push, pop;

  always_comb begin
    cls_c.alu = ALU_ADD;
    case (in_data.command)
      CMD_IN, CMD_PUSH: cls_c.kind = K_PUSH;
      CMD_OUT:          cls_c.kind = K_POP;
      CMD_HALT:         cls_c.kind = K_HALT;
      CMD_ADD: begin
        cls_c.kind = K_ARITH;
        cls_c.alu  = ALU_ADD;
      end
      CMD_SUB: begin
        cls_c.kind = K_ARITH;
        cls_c.alu  = ALU_SUB;
      end
      CMD_MUL: begin
        cls_c.kind = K_ARITH;
        cls_c.alu  = ALU_MUL;
      end
      CMD_DIV: begin
        cls_c.kind = K_ARITH;
        cls_c.alu  = ALU_DIV;
      end
      default:          cls_c.kind = K_BAD;
    endcase
  end

  // Narrow value widths saturate the 32-bit operand; wide ones sign-extend it.
  always_comb begin
    op65 = {{33{in_data.operand[31]}}, in_data.operand};
    if (op65 > VMAX65) begin
      sat65 = VMAX65;
    end else if (op65 < VMIN65) begin
      sat65 = VMIN65;
    end else begin
      sat65 = op65;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_class  = cls_r[rp_r];
  assign q_value  = val_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cls_r[wp_r] <= cls_c;
      val_r[wp_r] <= sat65[VALUE_WIDTH-1:0];
    end
  end

endmodule

@@ design/scm_back.sv @@
// Back end: operand stack memory, sequencer, shift-add multiplier and
// restoring divider, plus the result register. Depends on scm_pkg.
module scm_back import scm_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  cmd_class_t             q_class,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output calc_out_t              out_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int NW = W + FRAC_BITS;
  localparam int MW = 2 * W + FRAC_BITS;
  localparam int IW = $clog2(NW);
  localparam logic signed [64:0] I32MAX = 65'sd2147483647;
  localparam logic signed [64:0] I32MIN = -65'sd2147483648;

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en;

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cm1, cm2;
  alu_t          alu_r, alu_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  ma_r, ma_nxt, mb_r, mb_nxt, t_r, t_nxt, rem_r, rem_nxt, res_r, res_nxt;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [31:0]   dval_r, dval_nxt;
  logic          dpres_r, dpres_nxt;
  status_t       dstat_r, dstat_nxt;
  logic          out_valid_r, out_valid_nxt;
  calc_out_t     out_data_r, out_data_nxt;

  logic [W:0]    sum_c, sx, tx;
  logic [W:0]    mstep, rem2, diff;
  logic [2*W:0]  acc_sh;
  logic [MW-1:0] mag, lim, msat;
  logic signed [64:0] x65;
  logic [31:0]   pop32;

  function automatic logic [W-1:0] absv(input logic [W-1:0] v);
    absv = v[W-1] ? (W'(0) - v) : v;
  endfunction

  assign cm1 = count_r - CW'(1);
  assign cm2 = count_r - CW'(2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    x65 = {{(65 - W){rd_data_r[W-1]}}, rd_data_r};
    if (x65 > I32MAX) begin
      pop32 = I32MAX[31:0];
    end else if (x65 < I32MIN) begin
      pop32 = I32MIN[31:0];
    end else begin
      pop32 = x65[31:0];
    end
  end

  always_comb begin
    sx     = {rd_data_r[W-1], rd_data_r};
    tx     = {t_r[W-1], t_r};
    sum_c  = (alu_r == ALU_SUB) ? (sx - tx) : (sx + tx);
    mstep  = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, ma_r} : '0);
    acc_sh = {mstep, acc_r[W-1:0]};
    rem2   = {rem_r, num_r[NW-1]};
    diff   = rem2 - {1'b0, mb_r};
    mag    = (alu_r == ALU_MUL) ? MW'(acc_r >> FRAC_BITS) : MW'(num_r);
    lim    = (MW'(1) << (W - 1)) - MW'(!neg_r);
    msat   = (mag > lim) ? lim : mag;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    alu_nxt       = alu_r;
    neg_nxt       = neg_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    it_nxt        = it_r;
    dval_nxt      = dval_r;
    dpres_nxt     = dpres_r;
    dstat_nxt     = dstat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_ready       = 1'b0;
    rd_addr       = cm1[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = q_value;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready   = 1'b1;
          dval_nxt  = '0;
          dpres_nxt = 1'b0;
          dstat_nxt = ST_OK;
          alu_nxt   = q_class.alu;
          state_nxt = S_DONE;
          case (q_class.kind)
            K_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                dstat_nxt = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            K_POP: begin
              if (count_r == '0) begin
                dstat_nxt = ST_UNDERFLOW;
              end else begin
                state_nxt = S_POPW;
              end
            end
            K_ARITH: begin
              if (count_r < CW'(2)) begin
                dstat_nxt = ST_UNDERFLOW;
              end else begin
                state_nxt = S_RD_T;
              end
            end
            K_HALT:  count_nxt = '0;
            default: dstat_nxt = ST_UNKNOWN;
          endcase
        end
      end
      S_POPW: begin
        dval_nxt  = pop32;
        dpres_nxt = 1'b1;
        count_nxt = cm1;
        state_nxt = S_DONE;
      end
      S_RD_T: begin
        t_nxt     = rd_data_r;
        rd_addr   = cm2[AW-1:0];
        state_nxt = S_RD_S;
      end
      S_RD_S: begin
        neg_nxt = rd_data_r[W-1] ^ t_r[W-1];
        ma_nxt  = absv(rd_data_r);
        mb_nxt  = absv(t_r);
        it_nxt  = '0;
        case (alu_r)
          ALU_ADD, ALU_SUB: begin
            if (sum_c[W] != sum_c[W-1]) begin
              res_nxt = {sum_c[W], {(W - 1){~sum_c[W]}}};
            end else begin
              res_nxt = sum_c[W-1:0];
            end
            state_nxt = S_WR;
          end
          ALU_MUL: begin
            acc_nxt   = {{W{1'b0}}, absv(t_r)};
            state_nxt = S_MUL;
          end
          default: begin
            if (t_r == '0) begin
              dstat_nxt = ST_DIV_ZERO;
              state_nxt = S_DONE;
            end else begin
              rem_nxt   = '0;
              num_nxt   = {absv(rd_data_r), {FRAC_BITS{1'b0}}};
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        acc_nxt = acc_sh[2*W:1];
        it_nxt  = it_r + IW'(1);
        if (it_r == IW'(W - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_DIV: begin
        rem_nxt = diff[W] ? rem2[W-1:0] : diff[W-1:0];
        num_nxt = {num_r[NW-2:0], ~diff[W]};
        it_nxt  = it_r + IW'(1);
        if (it_r == IW'(NW - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        res_nxt   = neg_r ? (W'(0) - msat[W-1:0]) : msat[W-1:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        wr_en     = 1'b1;
        wr_addr   = cm2[AW-1:0];
        wr_data   = res_r;
        count_nxt = cm1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_value   = dval_r;
          out_data_nxt.out_present = dpres_r;
          out_data_nxt.status      = dstat_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alu_r      <= alu_nxt;
    neg_r      <= neg_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    acc_r      <= acc_nxt;
    num_r      <= num_nxt;
    it_r       <= it_nxt;
    dval_r     <= dval_nxt;
    dpres_r    <= dpres_nxt;
    dstat_r    <= dstat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_present |-> out_data_r.status == ST_OK)
    else $error("value reported with error status");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.out_present |-> out_data_r.out_value == '0)
    else $error("nonzero value without a popped value");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> state_r == S_IDLE)
    else $error("queue popped while busy");

endmodule

@@ design/stack_calculator_machine.sv @@
// Top level of the stack calculator machine.
// Instantiates scm_front and scm_back; depends on scm_pkg.
//
// Each input transaction carries one instruction (in/push, out, add, sub,
// mul, div, halt) on signed fixed-point values with 16 fraction bits, and
// each produces exactly one result transaction with a value, a present flag
// and a status. The front end decodes instructions and converts operands
// into a two-entry queue, so new transactions are taken while the back end
// works. The back end runs one instruction at a time. Mul and div iterate in
// one-bit-per-cycle multiplier and divider loops, and out and the arithmetic
// instructions read the stack through the single read port of the stack
// memory, which is read one entry per cycle. The result waits in an output
// register; a failed instruction leaves the stack unchanged.
module stack_calculator_machine import scm_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  calc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output calc_out_t out_data
);

  // Decoded instruction queue between the two halves.
  logic                   q_valid;
  logic                   q_ready;
  cmd_class_t             q_class;
  logic [VALUE_WIDTH-1:0] q_value;

  scm_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_class  (q_class),
    .q_value  (q_value)
  );

  scm_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_class   (q_class),
    .q_value   (q_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/stack_calculator_machine_test.sv @@
// Self-checking testbench for the stack calculator machine.
// Drives instruction transactions, predicts every result in the bench itself, compares
// results field by field. Depends on scm_pkg and stack_calculator_machine.
module stack_calculator_machine_test;
  import scm_pkg::*;

  localparam int DEPTH = 16;
  localparam int NUM_RANDOM = 930;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  calc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  calc_out_t out_data;

  stack_calculator_machine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Instructions waiting to be driven, and results predicted but not yet seen.
  calc_in_t  instr_queue[$];
  calc_out_t result_queue[$];

  // The bench's own copy of the stack.
  longint calc_stack[DEPTH];
  int     calc_depth;

  int  error_count;
  // When set, the driver waits until every predicted result has arrived.
  bit  drain_request;
  // When nonzero, the receiver holds out_ready low once, loading this value into its stall counter.
  int  hold_request;

  function automatic longint clamp_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  // Product truncated toward zero to 16 fraction bits, then saturated.
  function automatic longint fixed_mul(longint s, longint t);
    longint mag;
    mag = ((s < 0) ? -s : s) * ((t < 0) ? -t : t);
    mag = mag >>> FRAC_BITS;
    return clamp_q(((s < 0) != (t < 0)) ? -mag : mag);
  endfunction

  // Quotient truncated toward zero; the divisor is never zero here.
  function automatic longint fixed_div(longint s, longint t);
    longint mag;
    mag = (((s < 0) ? -s : s) <<< FRAC_BITS) / ((t < 0) ? -t : t);
    return clamp_q(((s < 0) != (t < 0)) ? -mag : mag);
  endfunction

  // Applies one instruction to the bench's stack and returns its result.
  function automatic calc_out_t execute_instr(calc_in_t it);
    calc_out_t r;
    longint s, t, v;
    r = '0;
    r.status = ST_OK;
    case (it.command)
      CMD_IN, CMD_PUSH: begin
        if (calc_depth >= DEPTH) r.status = ST_OVERFLOW;
        else begin
          calc_stack[calc_depth] = longint'(it.operand);
          calc_depth++;
        end
      end
      CMD_OUT: begin
        if (calc_depth == 0) r.status = ST_UNDERFLOW;
        else begin
          calc_depth--;
          r.out_value = calc_stack[calc_depth][31:0];
          r.out_present = 1'b1;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (calc_depth < 2) r.status = ST_UNDERFLOW;
        else begin
          t = calc_stack[calc_depth-1];
          s = calc_stack[calc_depth-2];
          if (it.command == CMD_DIV && t == 0) r.status = ST_DIV_ZERO;
          else begin
            case (it.command)
              CMD_ADD: v = clamp_q(s + t);
              CMD_SUB: v = clamp_q(s - t);
              CMD_MUL: v = fixed_mul(s, t);
              default: v = fixed_div(s, t);
            endcase
            calc_depth--;
            calc_stack[calc_depth-1] = v;
          end
        end
      end
      CMD_HALT: calc_depth = 0;
      default: r.status = ST_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic calc_in_t make_instr(logic [3:0] c, logic [31:0] v);
    calc_in_t it;
    it.command = c;
    it.operand = v;
    return it;
  endfunction

  // Operand values lean toward the saturation edges, zero and small numbers.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC_BITS;
      4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal arithmetic on a populated stack, with some noise.
  function automatic logic [3:0] rand_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return CMD_PUSH - logic'($urandom_range(0, 1));
    if (pick < 42) return CMD_ADD;
    if (pick < 54) return CMD_SUB;
    if (pick < 66) return CMD_MUL;
    if (pick < 78) return CMD_DIV;
    if (pick < 90) return CMD_OUT;
    if (pick < 94) return CMD_HALT;
    return 4'(8 + $urandom_range(0, 7));
  endfunction

  // Driver: one transaction from the queue at a time, with a random gap before each.
  int  gap_left;
  bit  gap_drawn;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_drawn <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      // Hold the offered transaction until it is accepted.
    end else if (drain_request && result_queue.size() != 0) begin
      in_valid <= 1'b0;
    end else if (instr_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!gap_drawn) begin
      // Skew toward back-to-back transactions so stretches without gaps occur.
      gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      gap_drawn <= 1'b1;
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else begin
      in_data <= instr_queue[0];
      result_queue.push_back(execute_instr(instr_queue[0]));
      void'(instr_queue.pop_front());
      in_valid <= 1'b1;
      gap_drawn <= 1'b0;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // draws the receiver's stall for the next one.
  int stall_left;
  bit hold_taken;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $error("result transaction with no prediction waiting");
          error_count++;
        end else begin
          if (out_data.out_value !== result_queue[0].out_value) begin
            $error("out_value: expected %h actual %h",
                   result_queue[0].out_value, out_data.out_value);
            error_count++;
          end
          if (out_data.out_present !== result_queue[0].out_present) begin
            $error("out_present: expected %b actual %b",
                   result_queue[0].out_present, out_data.out_present);
            error_count++;
          end
          if (out_data.status !== result_queue[0].status) begin
            $error("status: expected %0d actual %0d",
                   result_queue[0].status, out_data.status);
            error_count++;
          end
          void'(result_queue.pop_front());
        end
      end
      if (hold_request > 0 && !hold_taken) begin
        stall_left <= hold_request;
        hold_taken <= 1'b1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        if ($urandom_range(0, 2) == 0) begin
          stall_left <= $urandom_range(0, 17);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int settle;
    drain_request = 1'b0;
    hold_request = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: underflow on an empty stack, unknown codes, the saturation
    // edges of add and sub, mul and div on zero, division by zero, a full stack and halt.
    instr_queue.push_back(make_instr(CMD_OUT, 32'h0));
    instr_queue.push_back(make_instr(CMD_ADD, 32'h0));
    instr_queue.push_back(make_instr(4'd8, 32'hffffffff));
    instr_queue.push_back(make_instr(4'd15, 32'h0));
    instr_queue.push_back(make_instr(CMD_IN, 32'h7fffffff));
    instr_queue.push_back(make_instr(CMD_PUSH, 32'h00010000));
    instr_queue.push_back(make_instr(CMD_ADD, 32'h0));
    instr_queue.push_back(make_instr(CMD_PUSH, 32'h80000000));
    instr_queue.push_back(make_instr(CMD_SUB, 32'h0));
    instr_queue.push_back(make_instr(CMD_PUSH, 32'h0));
    instr_queue.push_back(make_instr(CMD_DIV, 32'h0));
    instr_queue.push_back(make_instr(CMD_PUSH, 32'hffff0000));
    instr_queue.push_back(make_instr(CMD_MUL, 32'h0));
    instr_queue.push_back(make_instr(CMD_PUSH, 32'h00000001));
    instr_queue.push_back(make_instr(CMD_DIV, 32'h0));
    instr_queue.push_back(make_instr(CMD_OUT, 32'h0));
    instr_queue.push_back(make_instr(CMD_OUT, 32'h0));
    instr_queue.push_back(make_instr(CMD_HALT, 32'h0));
    for (int i = 0; i < DEPTH + 1; i++)
      instr_queue.push_back(make_instr(CMD_PUSH, rand_operand()));
    instr_queue.push_back(make_instr(CMD_HALT, 32'h0));

    // Random part. A long receiver hold-off lands early, and halfway through
    // the sender waits for every outstanding result.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 40) begin
        wait (instr_queue.size() == 0);
        hold_request = 300;
      end
      if (n == NUM_RANDOM / 2) begin
        wait (instr_queue.size() == 0);
        drain_request = 1'b1;
        wait (result_queue.size() == 0);
        drain_request = 1'b0;
      end
      instr_queue.push_back(make_instr(rand_command(), rand_operand()));
    end

    wait (instr_queue.size() == 0 && !(in_valid && !in_ready));
    wait (result_queue.size() == 0);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (error_count == 0 && result_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Guard: a time-out that ends the run as failed if it has not finished.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/scm_pkg.sv
design/scm_front.sv
design/scm_back.sv
design/stack_calculator_machine.sv
dv/stack_calculator_machine_test.sv
